### design/bhnf_pkg.sv
// ----------------------------------------------------------------------------
// bhnf_pkg
// Types and constants for the Barnes-Hut node force core.
// ----------------------------------------------------------------------------
`default_nettype none

package bhnf_pkg;

    // outcome codes
    localparam logic [1:0] OUTC_EMPTY      = 2'd0;
    localparam logic [1:0] OUTC_COINCIDENT = 2'd1;
    localparam logic [1:0] OUTC_ACCEPTED   = 2'd2;
    localparam logic [1:0] OUTC_OPEN       = 2'd3;

    // softening eps = 0.01 in 2^-30 units, G = 0.1 in 2^-32 units
    localparam logic [63:0] EPS_Q30   = 64'd10737418;
    localparam logic [31:0] G_Q32     = 32'd429496730;
    localparam logic [15:0] THETA_RST = 16'd2048;
    localparam logic [46:0] MAG_MAX   = {47{1'b1}};
    localparam logic [31:0] CNT_MAX   = 32'hFFFF_FFFF;

    typedef struct packed {
        logic        first_of_body;
        logic [31:0] target_x;
        logic [31:0] target_y;
        logic [31:0] target_mass;
        logic [31:0] node_mass;
        logic [31:0] node_center_x;
        logic [31:0] node_center_y;
        logic [31:0] node_size;
        logic        node_is_leaf;
        logic        node_empty;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  outcome;
        logic [47:0] force_x_total;
        logic [47:0] force_y_total;
        logic [31:0] accepted_count;
    } t_out_item;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SQX,
        S_SQY,
        S_D2,
        S_SQRT_D,
        S_THETA,
        S_TEST,
        S_SQRT_E,
        S_MASS,
        S_G_LO,
        S_G_HI,
        S_G_SUM,
        S_DIV_F,
        S_AX_LO,
        S_AX_HI,
        S_AX_SUM,
        S_DIV_A,
        S_AX_ACC,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

### design/barnes_hut_node_force_core.sv
// ----------------------------------------------------------------------------
// barnes_hut_node_force_core
// One quadtree node visit for one target body: skip, open or accept with
// softened gravity, accumulating saturated Q24.24 force sums.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (i_in_valid / o_in_ready) takes one node visit; output
//   channel (o_out_valid / i_out_ready) returns one result for every visit.
//   o_in_ready is high only while the core is idle, so one visit is worked
//   on at a time.
//   An empty or coincident node goes from idle straight to the output
//   state, a node to be opened leaves after the theta test and an accepted
//   node runs the force path. The work uses one shared 32x32 multiplier, a
//   one-bit-per-cycle square root (32 steps, run twice) and a restoring
//   divider at one quotient bit per cycle (64 steps, run three times).
//   With no stall the core is ready for the next visit in the cycle after
//   the result transfer.
//   The result stays on the output until transferred; a stalled receiver
//   holds the core in its output state and no new visit is taken.
//   opening_theta is to be written via i_cfg_we / i_cfg_data only while
//   idle; the core does not enforce this. Reset (synchronous, active low)
//   clears the force sums, counter and control state and sets theta to 0.5.
// ----------------------------------------------------------------------------
`default_nettype none

module barnes_hut_node_force_core
    import bhnf_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_item,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_item,
    input  wire logic      i_cfg_we,
    input  wire logic [15:0] i_cfg_data
);

    t_state r_state, n_state;

    logic [15:0] r_theta;
    logic signed [47:0] r_fx, r_fy;
    logic [31:0] r_cnt;
    logic [1:0]  r_outcome;

    // latched visit
    logic [31:0] r_ax, r_ay, r_tm, r_nm, r_size;
    logic        r_neg_x, r_neg_y, r_leaf, r_axis;

    // shared multiplier
    logic [31:0] mul_a, mul_b;
    logic [63:0] r_prod;

    // intermediate values
    logic [62:0] r_d2;
    logic [63:0] r_d2e, r_de, r_p, r_gp, r_f, r_lo96;

    // shared square root unit
    logic [63:0] r_rad, r_res, r_bit;
    logic [63:0] sq_t;
    logic        sq_ge;

    // shared divider
    logic [63:0] r_rem, r_num, r_q, r_dvs;
    logic        r_div_sat;
    logic [5:0]  r_it;
    logic [63:0] dv_sh;
    logic        dv_ge;

    // combinational helpers
    logic signed [32:0] dx, dy;
    logic [62:0] d2_sum;
    logic [63:0] gp_sum, f_hi;
    logic [95:0] p96;
    logic [63:0] q_fin;
    logic [46:0] mag;
    logic signed [48:0] acc_old, acc_new, delta;
    logic signed [47:0] acc_sat;
    logic [31:0] axis_mag;
    logic        accept_in, open_test;

    assign accept_in = i_in_valid && o_in_ready;

    // signed deltas, also used for the coincidence check
    assign dx = {i_in_item.node_center_x[31], i_in_item.node_center_x}
              - {i_in_item.target_x[31], i_in_item.target_x};
    assign dy = {i_in_item.node_center_y[31], i_in_item.node_center_y}
              - {i_in_item.target_y[31], i_in_item.target_y};

    // square root step
    assign sq_t  = r_res + r_bit;
    assign sq_ge = (r_rad >= sq_t);

    // divider step
    assign dv_sh = {r_rem[62:0], r_num[63]};
    assign dv_ge = r_rem[63] || (dv_sh >= r_dvs);

    assign d2_sum    = r_d2 + {1'b0, r_prod[63:2]};
    assign gp_sum    = r_gp + r_prod;
    assign f_hi      = {42'd0, gp_sum[63:42]};
    assign p96       = {r_prod, 32'd0} + {32'd0, r_lo96};
    assign open_test = ({5'd0, r_size, 11'd0} < r_prod[47:0]);
    assign axis_mag  = r_axis ? r_ay : r_ax;

    // axis accumulate with saturation
    assign q_fin   = r_div_sat ? {64{1'b1}} : r_q;
    assign mag     = (q_fin > {17'd0, MAG_MAX}) ? MAG_MAX : q_fin[46:0];
    assign delta   = ((r_axis ? r_neg_y : r_neg_x))
                   ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
    assign acc_old = r_axis ? {r_fy[47], r_fy} : {r_fx[47], r_fx};
    assign acc_new = acc_old + delta;
    always_comb begin
        if (acc_new > 49'sd140737488355327) begin
            acc_sat = 48'sh7FFF_FFFF_FFFF;
        end else if (acc_new < -49'sd140737488355328) begin
            acc_sat = 48'sh8000_0000_0000;
        end else begin
            acc_sat = acc_new[47:0];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept_in) begin
                    if (i_in_item.node_empty || (dx == 33'sd0 && dy == 33'sd0)) begin
                        n_state = S_OUT;
                    end else begin
                        n_state = S_SQX;
                    end
                end
            end
            S_SQX:    n_state = S_SQY;
            S_SQY:    n_state = S_D2;
            S_D2:     n_state = S_SQRT_D;
            S_SQRT_D: if (r_bit[0]) n_state = S_THETA;
            S_THETA:  n_state = S_TEST;
            S_TEST:   n_state = (r_leaf || open_test) ? S_SQRT_E : S_OUT;
            S_SQRT_E: if (r_bit[0]) n_state = S_MASS;
            S_MASS:   n_state = S_G_LO;
            S_G_LO:   n_state = S_G_HI;
            S_G_HI:   n_state = S_G_SUM;
            S_G_SUM:  n_state = S_DIV_F;
            S_DIV_F:  if (r_it == 6'd63) n_state = S_AX_LO;
            S_AX_LO:  n_state = S_AX_HI;
            S_AX_HI:  n_state = S_AX_SUM;
            S_AX_SUM: n_state = S_DIV_A;
            S_DIV_A:  if (r_it == 6'd63) n_state = S_AX_ACC;
            S_AX_ACC: n_state = r_axis ? S_OUT : S_AX_LO;
            S_OUT:    if (i_out_ready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // handshake and multiplier operands
    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        mul_a       = 32'd0;
        mul_b       = 32'd0;
        unique case (r_state)
            S_IDLE:  o_in_ready = 1'b1;
            S_SQX:   begin mul_a = r_ax; mul_b = r_ax; end
            S_SQY:   begin mul_a = r_ay; mul_b = r_ay; end
            S_THETA: begin mul_a = {16'd0, r_theta}; mul_b = r_res[31:0]; end
            S_MASS:  begin mul_a = r_tm; mul_b = r_nm; end
            S_G_LO:  begin mul_a = r_prod[31:0]; mul_b = G_Q32; end
            S_G_HI:  begin mul_a = r_p[63:32]; mul_b = G_Q32; end
            S_AX_LO: begin mul_a = r_f[31:0]; mul_b = axis_mag; end
            S_AX_HI: begin mul_a = r_f[63:32]; mul_b = axis_mag; end
            S_OUT:   o_out_valid = 1'b1;
            default: ;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_theta <= THETA_RST;
            r_fx    <= '0;
            r_fy    <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_theta <= i_cfg_data;
            end
            if (accept_in && i_in_item.first_of_body) begin
                r_fx <= '0;
                r_fy <= '0;
            end
            if (r_state == S_AX_ACC) begin
                if (r_axis) begin
                    r_fy <= acc_sat;
                    if (r_cnt != CNT_MAX) begin
                        r_cnt <= r_cnt + 32'd1;
                    end
                end else begin
                    r_fx <= acc_sat;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        unique case (r_state)
            S_IDLE: begin
                if (accept_in) begin
                    r_ax    <= dx[32] ? 32'(-dx) : dx[31:0];
                    r_ay    <= dy[32] ? 32'(-dy) : dy[31:0];
                    r_neg_x <= dx[32];
                    r_neg_y <= dy[32];
                    r_tm    <= i_in_item.target_mass;
                    r_nm    <= i_in_item.node_mass;
                    r_size  <= i_in_item.node_size;
                    r_leaf  <= i_in_item.node_is_leaf;
                    r_axis  <= 1'b0;
                    if (i_in_item.node_empty) begin
                        r_outcome <= OUTC_EMPTY;
                    end else begin
                        r_outcome <= OUTC_COINCIDENT;
                    end
                end
            end
            S_SQY: r_d2 <= {1'b0, r_prod[63:2]};
            S_D2: begin
                r_d2  <= d2_sum;
                r_d2e <= {1'b0, d2_sum} + EPS_Q30;
                r_rad <= {1'b0, d2_sum};
                r_res <= '0;
                r_bit <= 64'd1 << 62;
            end
            S_SQRT_D, S_SQRT_E: begin
                if (sq_ge) begin
                    r_rad <= r_rad - sq_t;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            S_TEST: begin
                if (r_leaf || open_test) begin
                    r_rad <= r_d2e;
                    r_res <= '0;
                    r_bit <= 64'd1 << 62;
                end else begin
                    r_outcome <= OUTC_OPEN;
                end
            end
            S_MASS: r_de <= r_res;
            S_G_LO: r_p <= r_prod;
            S_G_HI: r_gp <= {32'd0, r_prod[63:32]};
            S_G_SUM: begin
                r_rem     <= f_hi;
                r_num     <= {gp_sum[41:0], 22'd0};
                r_dvs     <= r_d2e;
                r_div_sat <= (f_hi >= r_d2e);
                r_q       <= '0;
                r_it      <= '0;
            end
            S_DIV_F, S_DIV_A: begin
                r_rem <= dv_ge ? dv_sh - r_dvs : dv_sh;
                r_num <= {r_num[62:0], 1'b0};
                r_q   <= {r_q[62:0], dv_ge};
                r_it  <= r_it + 6'd1;
                if (r_state == S_DIV_F && r_it == 6'd63) begin
                    r_f <= r_div_sat ? {64{1'b1}} : {r_q[62:0], dv_ge};
                end
            end
            S_AX_HI: r_lo96 <= r_prod;
            S_AX_SUM: begin
                r_rem     <= {32'd0, p96[95:64]};
                r_num     <= p96[63:0];
                r_dvs     <= {r_de[62:0], 1'b0};
                r_div_sat <= ({32'd0, p96[95:64]} >= {r_de[62:0], 1'b0});
                r_q       <= '0;
                r_it      <= '0;
            end
            S_AX_ACC: begin
                r_axis <= 1'b1;
                if (r_axis) begin
                    r_outcome <= OUTC_ACCEPTED;
                end
            end
            default: ;
        endcase
    end

    // result fields
    always_comb begin
        o_out_item.outcome        = r_outcome;
        o_out_item.force_x_total  = r_fx;
        o_out_item.force_y_total  = r_fy;
        o_out_item.accepted_count = r_cnt;
    end

endmodule

`default_nettype wire

### tb/tb_barnes_hut_node_force_core.sv
// ----------------------------------------------------------------------------
// tb_barnes_hut_node_force_core
// Self-checking bench for the node force core: a directed table followed by
// random node visits, results compared with table entries or an in-bench force
// predictor, over several theta values and with random gaps on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_barnes_hut_node_force_core;
    import bhnf_pkg::*;

    localparam int RANDOM_VISITS = 2000;
    localparam int SETTLE_CYCLES = 300;

    typedef struct {
        t_in_item  visit;
        bit        typed;
        t_out_item result;
    } t_table_row;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_item;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_item;
    logic      i_cfg_we;
    logic [15:0] i_cfg_data;

    // predictor state
    logic [15:0]    theta_model;
    longint         fx_sum_model;
    longint         fy_sum_model;
    logic [31:0]    count_model;

    t_out_item      expected_results[$];
    bit             typed_pending[$];
    t_out_item      typed_pending_result[$];
    int             mismatches;
    int             results_seen;
    int             accepted_nodes;
    int             opened_nodes;
    bit             steady;

    barnes_hut_node_force_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // floor square root of a 64 bit value
    function automatic logic [63:0] floor_sqrt(input logic [63:0] val);
        logic [63:0] x;
        logic [63:0] res;
        logic [63:0] b;
        x = val;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // signed force on one axis, magnitude clamped to 2^47-1, toward zero
    function automatic longint axis_force(input logic [63:0] f, input longint delta,
                                          input logic [63:0] de);
        logic [127:0] mag;
        logic [127:0] q;
        mag = (delta < 0) ? -delta : delta;
        q = ({64'd0, f} * mag) / ({64'd0, de} << 1);
        if (q > {81'd0, MAG_MAX}) q = {81'd0, MAG_MAX};
        return (delta < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function automatic longint clamp_sum(input longint s);
        if (s > 64'sh7FFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF;
        if (s < -64'sh8000_0000_0000) return -64'sh8000_0000_0000;
        return s;
    endfunction

    // one node visit: update the force sums and counter, return the result
    function automatic t_out_item visit_node(input t_in_item v);
        t_out_item   r;
        longint      dx, dy;
        logic [63:0] ax, ay, d2, d, d2e, de, prod, gp, f;
        logic [127:0] wide;
        if (v.first_of_body) begin
            fx_sum_model = 0;
            fy_sum_model = 0;
        end
        if (v.node_empty) begin
            r.outcome = OUTC_EMPTY;
        end else if (v.target_x == v.node_center_x && v.target_y == v.node_center_y) begin
            r.outcome = OUTC_COINCIDENT;
        end else begin
            dx = longint'(signed'(v.node_center_x)) - longint'(signed'(v.target_x));
            dy = longint'(signed'(v.node_center_y)) - longint'(signed'(v.target_y));
            ax = (dx < 0) ? -dx : dx;
            ay = (dy < 0) ? -dy : dy;
            d2 = ((ax * ax) >> 2) + ((ay * ay) >> 2);
            d = floor_sqrt(d2);
            if (v.node_is_leaf ||
                ({64'd0, v.node_size} << 11) < {112'd0, theta_model} * {64'd0, d}) begin
                d2e = d2 + EPS_Q30;
                de = floor_sqrt(d2e);
                prod = {32'd0, v.target_mass} * {32'd0, v.node_mass};
                wide = {64'd0, prod} * {96'd0, G_Q32};
                gp = wide[95:32];
                wide = ({64'd0, gp} << 22) / {64'd0, d2e};
                f = (wide[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : wide[63:0];
                fx_sum_model = clamp_sum(fx_sum_model + axis_force(f, dx, de));
                fy_sum_model = clamp_sum(fy_sum_model + axis_force(f, dy, de));
                if (count_model != CNT_MAX) count_model = count_model + 1;
                r.outcome = OUTC_ACCEPTED;
            end else begin
                r.outcome = OUTC_OPEN;
            end
        end
        r.force_x_total = fx_sum_model[47:0];
        r.force_y_total = fy_sum_model[47:0];
        r.accepted_count = count_model;
        return r;
    endfunction

    function automatic t_in_item make_visit(input bit first, input logic [31:0] tx,
            input logic [31:0] ty, input logic [31:0] tm, input logic [31:0] nm,
            input logic [31:0] cx, input logic [31:0] cy, input logic [31:0] size,
            input bit leaf, input bit empty);
        t_in_item v;
        v.first_of_body = first;
        v.target_x = tx;
        v.target_y = ty;
        v.target_mass = tm;
        v.node_mass = nm;
        v.node_center_x = cx;
        v.node_center_y = cy;
        v.node_size = size;
        v.node_is_leaf = leaf;
        v.node_empty = empty;
        return v;
    endfunction

    // mostly sensible visits, some full-range noise
    function automatic t_in_item random_visit();
        t_in_item     v;
        int           spread;
        logic [255:0] noise;
        noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom};
        v = noise[$bits(t_in_item)-1:0];
        if ($urandom_range(0, 9) < 8) begin
            spread = $urandom_range(4, 30);
            v.target_x = $urandom & ((32'd1 << spread) - 1);
            v.target_y = $urandom & ((32'd1 << spread) - 1);
            v.node_center_x = v.target_x + ($urandom & ((32'd1 << spread) - 1))
                              - (32'd1 << (spread - 1));
            v.node_center_y = v.target_y + ($urandom & ((32'd1 << spread) - 1))
                              - (32'd1 << (spread - 1));
            v.target_mass = $urandom >> $urandom_range(0, 31);
            v.node_mass = $urandom >> $urandom_range(0, 31);
            v.node_size = $urandom >> $urandom_range(0, 31);
            v.first_of_body = ($urandom_range(0, 7) == 0);
            v.node_empty = ($urandom_range(0, 15) == 0);
            if ($urandom_range(0, 19) == 0) begin
                v.node_center_x = v.target_x;
                v.node_center_y = v.target_y;
            end
        end
        return v;
    endfunction

    // write theta once the core is drained
    task automatic set_theta(input logic [15:0] value);
        wait (expected_results.size() == 0 && typed_pending.size() == 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        theta_model = value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // offer one visit, with an optional gap, and hold it until the transfer
    task automatic send_visit(input t_in_item v, input bit typed, input t_out_item r);
        if (!steady && $urandom_range(0, 99) < 35) begin
            i_in_valid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(0, 99) < 35);
        end
        typed_pending.push_back(typed);
        typed_pending_result.push_back(r);
        i_in_valid <= 1'b1;
        i_in_item <= v;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    // prediction at each input transfer
    always @(posedge i_clk) begin
        t_out_item r;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            r = visit_node(i_in_item);
            if (r.outcome == OUTC_ACCEPTED) accepted_nodes++;
            if (r.outcome == OUTC_OPEN) opened_nodes++;
            if (typed_pending.pop_front()) r = typed_pending_result.pop_front();
            else void'(typed_pending_result.pop_front());
            expected_results.push_back(r);
        end
    end

    // check each result transfer against the oldest expectation
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", o_out_item);
            end else begin
                want = expected_results.pop_front();
                if (want.outcome !== o_out_item.outcome ||
                    want.force_x_total !== o_out_item.force_x_total ||
                    want.force_y_total !== o_out_item.force_y_total ||
                    want.accepted_count !== o_out_item.accepted_count) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: expected %p, got %p",
                                 results_seen, want, o_out_item);
                end
            end
        end
    end

    // receiver stalls
    always @(negedge i_clk) begin
        i_out_ready <= steady || ($urandom_range(0, 99) >= 35);
    end

    initial begin
        #50ms;
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        t_table_row table_rows[$];
        t_table_row row;
        t_out_item  none;
        logic [15:0] thetas[4];
        none = '0;
        mismatches = 0;
        results_seen = 0;
        accepted_nodes = 0;
        opened_nodes = 0;
        steady = 0;
        theta_model = THETA_RST;
        fx_sum_model = 0;
        fy_sum_model = 0;
        count_model = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_item = '0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table
        row = '{make_visit(1, 0, 0, 32'h10000, 32'h10000, 32'h10000, 0, 0, 1, 1), 1,
                t_out_item'{OUTC_EMPTY, 48'd0, 48'd0, 32'd0}};
        table_rows.push_back(row);
        row = '{make_visit(0, 32'h1234, 32'h5678, 32'h10000, 32'h10000, 32'h1234,
                           32'h5678, 0, 1, 0), 1,
                t_out_item'{OUTC_COINCIDENT, 48'd0, 48'd0, 32'd0}};
        table_rows.push_back(row);
        row = '{make_visit(0, 0, 0, 32'h10000, 32'h10000, 32'h10000, 0, 32'h4000_0000, 1, 0),
                0, none};
        table_rows.push_back(row);
        row = '{make_visit(0, 0, 0, 0, 32'hFFFF_FFFF, 0, 32'hFFFF0000, 32'h100, 1, 0),
                0, none};
        table_rows.push_back(row);
        row = '{make_visit(0, 0, 0, 32'h10000, 32'h10000, 32'h10000, 32'h10000,
                           32'hFFFF_FFFF, 0, 0), 0, none};
        table_rows.push_back(row);
        row = '{make_visit(0, 0, 0, 32'h10000, 32'h20000, 32'h0100_0000, 32'h0100_0000,
                           32'h1, 0, 0), 0, none};
        table_rows.push_back(row);
        row = '{make_visit(1, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                           32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 1, 0), 0, none};
        table_rows.push_back(row);
        row = '{make_visit(1, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                           32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 0), 0, none};
        table_rows.push_back(row);
        for (int k = 0; k < 4; k++) begin
            row = '{make_visit(k == 0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1, 0, 0, 1, 0),
                    0, none};
            table_rows.push_back(row);
            row = '{make_visit(0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0,
                               0, 1, 0), 0, none};
            table_rows.push_back(row);
        end
        row = '{make_visit(1, 32'h100, 0, 32'h10000, 32'h10000, 0, 0, 0, 0, 1), 0, none};
        table_rows.push_back(row);
        foreach (table_rows[k])
            send_visit(table_rows[k].visit, table_rows[k].typed, table_rows[k].result);

        // random visits over several theta settings, extremes included
        thetas[0] = 16'd0;
        thetas[1] = 16'hFFFF;
        thetas[2] = THETA_RST;
        thetas[3] = $urandom;
        for (int p = 0; p < 5; p++) begin
            i_in_valid <= 1'b0;
            if (p > 0) set_theta(thetas[p - 1]);
            for (int k = 0; k < RANDOM_VISITS / 5; k++) begin
                steady = (p == 2 && k >= 100 && k < 250);
                send_visit(random_visit(), 0, none);
            end
            steady = 0;
        end
        i_in_valid <= 1'b0;

        wait (expected_results.size() == 0 && typed_pending.size() == 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        $display("covered %0d results: %0d accepted, %0d opened, rest skipped",
                 results_seen, accepted_nodes, opened_nodes);
        $display("theta settings: reset value, zero, full scale, mid and random");
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

### files.f
design/bhnf_pkg.sv
design/barnes_hut_node_force_core.sv
tb/tb_barnes_hut_node_force_core.sv
